// ===== src/gf2ld_pkg.sv =====
// shared types, sizes and helpers for the gf2 linear dependence block
`default_nettype none

package gf2ld_pkg;

  localparam int MAX_LENGTH  = 64;
  localparam int MAX_VECTORS = 64;
  localparam int VEC_W       = 64;
  localparam int COEF_W      = 63;
  localparam int LEN_W       = 7;
  localparam int CNT_W       = $clog2(MAX_VECTORS + 1);
  localparam int IDX_W       = $clog2(MAX_VECTORS);

  typedef struct packed {
    logic [VEC_W-1:0] vector_bits;
    logic             last_vector;
  } in_item_t;

  typedef struct packed {
    logic              dependent;
    logic [COEF_W-1:0] coefficients;
    logic              coefficients_valid;
    logic              overflow;
  } out_item_t;

  // request travelling along the cell chain, row is shifted down one bit per cell
  typedef struct packed {
    logic                   valid;
    logic                   last;
    logic                   ovf;
    logic                   claimed;
    logic [IDX_W-1:0]       index;
    logic [MAX_LENGTH-1:0]  row;
    logic [MAX_VECTORS-1:0] combo;
  } token_t;

  // coordinates below len are kept, len above MAX_LENGTH saturates
  function automatic logic [MAX_LENGTH-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [MAX_LENGTH-1:0] m;
    for (int j = 0; j < MAX_LENGTH; j++) begin
      m[j] = (LEN_W'(j) < len);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== src/gf2ld_cell.sv =====
// one pivot cell: holds a basis row and its combination mask, reduces passing requests
`default_nettype none

module gf2ld_cell
  import gf2ld_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   advance,
  input  token_t tok_in,
  output token_t tok_out
);

  logic                   slot_valid;
  logic [MAX_LENGTH-1:0]  pivot_row;
  logic [MAX_VECTORS-1:0] combo_mask;

  logic                   hit;
  logic                   reduce;
  logic                   claim;
  logic [MAX_LENGTH-1:0]  row_red;
  logic [MAX_VECTORS-1:0] own;
  token_t                 tok_next;

  assign hit     = tok_in.valid && !tok_in.ovf && !tok_in.claimed && tok_in.row[0];
  assign reduce  = hit && slot_valid;
  assign claim   = hit && !slot_valid;
  assign row_red = reduce ? (tok_in.row ^ pivot_row) : tok_in.row;
  assign own     = MAX_VECTORS'(1) << tok_in.index;

  always_comb begin
    tok_next         = tok_in;
    tok_next.row     = row_red >> 1;
    tok_next.combo   = reduce ? (tok_in.combo ^ combo_mask) : tok_in.combo;
    tok_next.claimed = tok_in.claimed || claim;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid    <= 1'b0;
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      tok_out <= tok_next;
      // end of set clears the slot once the last request has gone by
      if (tok_in.valid && tok_in.last) begin
        slot_valid <= 1'b0;
      end else if (claim) begin
        slot_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && claim) begin
      pivot_row  <= tok_in.row;
      combo_mask <= tok_in.combo ^ own;
    end
  end

endmodule

`default_nettype wire

// ===== src/gf2_linear_dependence_basis.sv =====
// top level: incremental gf2 xor basis built as a chain of pivot cells
//
//   channel | direction | handshake        | payload
//   in      | in        | in_valid/in_stall   | in_item_t  (vector_bits, last_vector)
//   out     | out       | out_valid/out_stall | out_item_t (dependent, coefficients, ...)
//   cfg     | in        | cfg_valid/cfg_ready | cfg_data   (vector_length)
//
// one request enters per cycle while the chain is not stalled; each one walks the
// cell chain one pivot cell after another, registered in every cell
// synchronous active-high reset clears every slot, the vector count and sets length 64
// a stalled result at the chain tail freezes the whole chain and raises in_stall
// cfg_ready is always high; a new length masks only requests entering after the write
`default_nettype none

module gf2_linear_dependence_basis
  import gf2ld_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_data
);

  // coordinate mask derived from vector_length at write time
  logic [MAX_LENGTH-1:0] coord_mask;
  // vectors taken so far in the current set
  logic [CNT_W-1:0]      count;

  logic                  advance;
  logic                  in_accept;
  logic                  full;
  token_t                chain [MAX_LENGTH+1];
  token_t                tail;
  logic                  dep;
  logic                  cvalid;
  logic [MAX_VECTORS+COEF_W-1:0] combo_wide;

  // whole chain moves together; it only halts when the tail result is held
  assign advance   = !(tail.valid && out_stall);
  assign in_stall  = !advance;
  assign in_accept = in_valid && advance;
  assign cfg_ready = 1'b1;
  assign full      = (count >= CNT_W'(MAX_VECTORS));

  always_ff @(posedge clk) begin
    if (rst) begin
      coord_mask <= '1;
    end else if (cfg_valid && cfg_ready) begin
      coord_mask <= len_mask(cfg_data);
    end
  end

  // set counter: cleared by the last vector, held once capacity is reached
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_accept) begin
      if (in_item.last_vector) begin
        count <= '0;
      end else if (!full) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // entry: mask the vector and tag it with its index in the set
  always_comb begin
    chain[0].valid   = in_valid;
    chain[0].last    = in_item.last_vector;
    chain[0].ovf     = full;
    chain[0].claimed = 1'b0;
    chain[0].index   = count[IDX_W-1:0];
    chain[0].row     = in_item.vector_bits[MAX_LENGTH-1:0] & coord_mask;
    chain[0].combo   = '0;
  end

  // cell p owns pivot coordinate p
  for (genvar p = 0; p < MAX_LENGTH; p++) begin : g_cell
    gf2ld_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .tok_in  (chain[p]),
      .tok_out (chain[p+1])
    );
  end

  assign tail = chain[MAX_LENGTH];

  // a request that no cell claimed and that did not overflow reduced to zero, so it is dependent
  assign dep        = tail.valid && !tail.claimed && !tail.ovf;
  assign cvalid     = dep && tail.last;
  assign combo_wide = {COEF_W'(0), tail.combo};

  assign out_valid = tail.valid;
  always_comb begin
    out_item.dependent          = dep;
    out_item.coefficients       = cvalid ? combo_wide[COEF_W-1:0] : '0;
    out_item.coefficients_valid = cvalid;
    out_item.overflow           = tail.valid && tail.ovf;
  end

`ifndef NO_ASSERTIONS
  a_dep_not_ovf : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.dependent && out_item.overflow))
    else $error("dependent and overflow both set");

  a_cvalid_dep : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.coefficients_valid |-> out_item.dependent)
    else $error("coefficients valid without dependence");

  a_count_range : assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_VECTORS))
    else $error("vector count beyond capacity");

  a_last_clears : assert property (@(posedge clk) disable iff (rst)
    in_accept && in_item.last_vector |=> count == '0)
    else $error("count not cleared after last vector");

  a_hold_stalls : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(tail.index) && out_valid)
    else $error("chain moved while result held");
`endif

endmodule

`default_nettype wire
